/* rtl/cma_pkg.sv */
// cma_pkg: shared constants, codes and types of the covariance matrix accumulator
// used by cma_front, cma_back and covariance_matrix_accumulator_core
// no dependencies
package cma_pkg;

  localparam int NUM_LANES = 8;
  localparam int IN_W      = 24;
  localparam int COV_W     = 48;
  localparam int IDX_W     = 3;
  localparam int NS_W      = 4;

  localparam int DEF_MAX_SERIES   = 8;
  localparam int DEF_MAX_BINS     = 1024;
  localparam int DEF_SAMPLE_WIDTH = 24;

  localparam logic [NS_W-1:0] NS_RESET = 4'd8;

  // register index on the configuration port
  localparam logic REG_SERIES_IN_USE = 1'b0;
  localparam logic REG_DIAGONAL_ONLY = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FEW_BINS = 2'd1,
    STATUS_DROPPED  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_ROW,
    BK_MUL,
    BK_ADD,
    BK_NSQ,
    BK_QMUL,
    BK_ERD,
    BK_ERD2,
    BK_EMUL,
    BK_ESUB,
    BK_EDIV,
    BK_EMIT
  } bk_state_e;

  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [COV_W-1:0] cov;
    status_e                 status;
    logic                    last;
  } result_t;

endpackage

/* rtl/cma_front.sv */
// cma_front: input side, trims lanes to the sample width and holds bins in a
// two-entry queue ahead of the back end; depends on cma_pkg
module cma_front #(
  parameter int MAX_SERIES   = cma_pkg::DEF_MAX_SERIES,
  parameter int SAMPLE_WIDTH = cma_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic [cma_pkg::IN_W-1:0]                sample_i [cma_pkg::NUM_LANES],
  input  logic                                    last_bin_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  output logic [MAX_SERIES*SAMPLE_WIDTH:0]        item_o,
  output logic                                    item_valid_o,
  input  logic                                    item_ready_i
);

  localparam int IW = MAX_SERIES * SAMPLE_WIDTH + 1;

  logic [IW-1:0] buf_q [2];
  logic [IW-1:0] packed_item;
  logic [1:0]    cnt_q, cnt_d;
  logic          wp_q, rp_q;
  logic          push, pop;

  always_comb begin
    for (int l = 0; l < MAX_SERIES; l++) begin
      packed_item[l*SAMPLE_WIDTH +: SAMPLE_WIDTH] = sample_i[l][SAMPLE_WIDTH-1:0];
    end
    packed_item[IW-1] = last_bin_i;
  end

  assign in_ready_o   = (cnt_q != 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = buf_q[rp_q];
  assign push         = in_valid_i & in_ready_o;
  assign pop          = item_valid_o & item_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wp_q] <= packed_item;
    end
  end

endmodule

/* rtl/cma_back.sv */
// cma_back: accumulates sums and pair products of each bin, then on the last
// bin works out and emits the matrix; depends on cma_pkg
module cma_back #(
  parameter int MAX_SERIES   = cma_pkg::DEF_MAX_SERIES,
  parameter int MAX_BINS     = cma_pkg::DEF_MAX_BINS,
  parameter int SAMPLE_WIDTH = cma_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [MAX_SERIES*SAMPLE_WIDTH:0] item_i,
  input  logic                             item_valid_i,
  output logic                             item_ready_o,
  input  logic [cma_pkg::NS_W-1:0]         series_in_use_i,
  input  logic                             diagonal_only_i,
  output cma_pkg::result_t                 res_o,
  output logic                             res_valid_o,
  input  logic                             res_ready_i
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int IW    = MAX_SERIES * SW + 1;
  localparam int LW    = $clog2(MAX_SERIES);
  localparam int PAIRS = MAX_SERIES * (MAX_SERIES + 1) / 2;
  localparam int PW    = $clog2(PAIRS);
  localparam int TW    = $clog2(2 * PAIRS + 2) + 1;
  localparam int NW    = $clog2(MAX_BINS + 1);
  localparam int SUMW  = SW + NW;
  localparam int PRODW = 2 * SW + NW;
  localparam int NPW   = NW + 1 + PRODW;
  localparam int SSW   = 2 * SUMW;
  localparam int DW0   = (NPW > SSW) ? NPW : SSW;
  localparam int DW    = ((DW0 > cma_pkg::COV_W) ? DW0 : cma_pkg::COV_W) + 1;
  localparam int QW    = 3 * NW;
  localparam int CW    = $clog2(DW);
  localparam int CVW   = cma_pkg::COV_W;
  localparam int XW    = cma_pkg::IDX_W;
  localparam int NSW   = cma_pkg::NS_W;

  localparam logic [LW-1:0] LANE_LAST = LW'(MAX_SERIES - 1);
  localparam logic [NW-1:0] BIN_CAP   = NW'(MAX_BINS);
  localparam logic [DW-1:0] POS_LIM   = {{(DW-CVW+1){1'b0}}, {(CVW-1){1'b1}}};
  localparam logic [DW-1:0] NEG_LIM   = {{(DW-CVW){1'b0}}, 1'b1, {(CVW-1){1'b0}}};

  cma_pkg::bk_state_e state_q, state_d;

  logic signed [SW-1:0]    x_q [MAX_SERIES];
  logic                    last_q;
  logic signed [SUMW-1:0]  ssum_q [MAX_SERIES];
  logic [NW-1:0]           bins_q;
  logic                    ovf_q;
  logic [LW-1:0]           ai_q, aj_q;
  logic [PW-1:0]           p_q;
  logic signed [SW-1:0]    xa_q;
  logic signed [2*SW-1:0]  prod_q;

  logic signed [PRODW-1:0] psum_mem [PAIRS];
  logic [PAIRS-1:0]        pvalid_q;
  logic signed [PRODW-1:0] rd_data_q;
  logic                    rd_hit_q;
  logic signed [PRODW-1:0] rd_eff;

  logic [XW-1:0]           ei_q, ej_q;
  logic signed [SUMW-1:0]  sa_q, sb_q;
  logic signed [PRODW-1:0] pe_q;
  logic signed [NPW-1:0]   np_q;
  logic signed [SSW-1:0]   ss_q;
  logic signed [DW-1:0]    diff;
  logic                    neg_q;
  logic [DW-1:0]           dq_q;
  logic [QW-1:0]           rem_q;
  logic [QW:0]             trial;
  logic [CW-1:0]           cnt_q;
  logic [2*NW-1:0]         nsq_q;
  logic [QW-1:0]           q_q;

  cma_pkg::result_t        res_q;
  logic                    res_valid_q;

  // control
  logic                    pop, emit_go, ent_last, skip_ent;
  logic [LW-1:0]           lane_sel;
  logic [PW-1:0]           raddr;
  logic [NSW-1:0]          ns_eff, ns_last;
  logic [XW-1:0]           ea, eb;
  logic [TW-1:0]           tri_v;
  logic [PW-1:0]           eidx;
  logic                    col_end, row_end;
  logic [CVW-1:0]          cov_v;

  // matrix size clamped to 1..MAX_SERIES
  always_comb begin
    if (series_in_use_i == '0) begin
      ns_eff = NSW'(1);
    end else if (series_in_use_i > NSW'(MAX_SERIES)) begin
      ns_eff = NSW'(MAX_SERIES);
    end else begin
      ns_eff = series_in_use_i;
    end
    ns_last = ns_eff - NSW'(1);
  end

  assign col_end  = ({1'b0, ej_q} == ns_last);
  assign row_end  = ({1'b0, ei_q} == ns_last);
  assign ent_last = col_end & row_end;
  assign ea       = (ei_q < ej_q) ? ei_q : ej_q;
  assign eb       = (ei_q < ej_q) ? ej_q : ei_q;
  // upper-triangle index of pair (a,b)
  assign tri_v    = TW'(ea) * (TW'(2 * MAX_SERIES + 1) - TW'(ea));
  assign eidx     = PW'((tri_v >> 1) + TW'(eb) - TW'(ea));
  assign rd_eff   = rd_hit_q ? rd_data_q : '0;
  assign trial    = {rem_q, dq_q[DW-1]};
  assign diff     = DW'(np_q) - DW'(ss_q);
  assign skip_ent = (bins_q < NW'(2)) | (diagonal_only_i & (ei_q != ej_q));

  // handshake, lane-select and read-address control
  always_comb begin
    pop      = (state_q == cma_pkg::BK_IDLE) & item_valid_i;
    emit_go  = (state_q == cma_pkg::BK_EMIT) & (~res_valid_q | res_ready_i);
    lane_sel = ai_q;
    raddr    = p_q;
    case (state_q)
      cma_pkg::BK_MUL:  lane_sel = aj_q;
      cma_pkg::BK_ERD:  begin
        lane_sel = ea[LW-1:0];
        raddr    = eidx;
      end
      cma_pkg::BK_ERD2: lane_sel = eb[LW-1:0];
      default:          lane_sel = ai_q;
    endcase
  end

  assign item_ready_o = (state_q == cma_pkg::BK_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cma_pkg::BK_IDLE: begin
        if (item_valid_i) begin
          if (bins_q < BIN_CAP) begin
            state_d = cma_pkg::BK_ROW;
          end else if (item_i[IW-1]) begin
            state_d = cma_pkg::BK_NSQ;
          end
        end
      end
      cma_pkg::BK_ROW: state_d = cma_pkg::BK_MUL;
      cma_pkg::BK_MUL: state_d = cma_pkg::BK_ADD;
      cma_pkg::BK_ADD: begin
        if (aj_q != LANE_LAST) begin
          state_d = cma_pkg::BK_MUL;
        end else if (ai_q != LANE_LAST) begin
          state_d = cma_pkg::BK_ROW;
        end else if (last_q) begin
          state_d = cma_pkg::BK_NSQ;
        end else begin
          state_d = cma_pkg::BK_IDLE;
        end
      end
      cma_pkg::BK_NSQ:  state_d = cma_pkg::BK_QMUL;
      cma_pkg::BK_QMUL: state_d = cma_pkg::BK_ERD;
      cma_pkg::BK_ERD:  state_d = cma_pkg::BK_ERD2;
      cma_pkg::BK_ERD2: state_d = cma_pkg::BK_EMUL;
      cma_pkg::BK_EMUL: state_d = cma_pkg::BK_ESUB;
      cma_pkg::BK_ESUB: state_d = cma_pkg::BK_EDIV;
      cma_pkg::BK_EDIV: begin
        if (cnt_q == CW'(DW - 1)) state_d = cma_pkg::BK_EMIT;
      end
      cma_pkg::BK_EMIT: begin
        if (emit_go) state_d = ent_last ? cma_pkg::BK_IDLE : cma_pkg::BK_ERD;
      end
      default: state_d = cma_pkg::BK_IDLE;
    endcase
  end

  // saturated quotient
  always_comb begin
    if (!neg_q) begin
      cov_v = (dq_q > POS_LIM) ? POS_LIM[CVW-1:0] : dq_q[CVW-1:0];
    end else begin
      cov_v = (dq_q > NEG_LIM) ? NEG_LIM[CVW-1:0] : CVW'(-dq_q[CVW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cma_pkg::BK_IDLE;
      bins_q      <= '0;
      ovf_q       <= 1'b0;
      pvalid_q    <= '0;
      res_valid_q <= 1'b0;
      for (int l = 0; l < MAX_SERIES; l++) ssum_q[l] <= '0;
    end else begin
      state_q <= state_d;
      if (pop) begin
        if (bins_q < BIN_CAP) begin
          bins_q <= bins_q + NW'(1);
          for (int l = 0; l < MAX_SERIES; l++) begin
            ssum_q[l] <= ssum_q[l] + SUMW'($signed(item_i[l*SW +: SW]));
          end
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (state_q == cma_pkg::BK_ADD) pvalid_q[p_q] <= 1'b1;
      if (emit_go) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
      // matrix done: accumulators clear
      if (emit_go && ent_last) begin
        bins_q   <= '0;
        ovf_q    <= 1'b0;
        pvalid_q <= '0;
        for (int l = 0; l < MAX_SERIES; l++) ssum_q[l] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      cma_pkg::BK_IDLE: begin
        if (pop) begin
          for (int l = 0; l < MAX_SERIES; l++) x_q[l] <= $signed(item_i[l*SW +: SW]);
          last_q <= item_i[IW-1];
          ai_q   <= '0;
          aj_q   <= '0;
          p_q    <= '0;
          ei_q   <= '0;
          ej_q   <= '0;
        end
      end
      cma_pkg::BK_ROW: xa_q <= x_q[lane_sel];
      cma_pkg::BK_MUL: prod_q <= xa_q * x_q[lane_sel];
      cma_pkg::BK_ADD: begin
        p_q <= p_q + PW'(1);
        if (aj_q != LANE_LAST) begin
          aj_q <= aj_q + LW'(1);
        end else begin
          ai_q <= ai_q + LW'(1);
          aj_q <= ai_q + LW'(1);
        end
      end
      cma_pkg::BK_NSQ:  nsq_q <= bins_q * bins_q;
      cma_pkg::BK_QMUL: q_q <= nsq_q * QW'(bins_q - NW'(1));
      cma_pkg::BK_ERD:  sa_q <= ssum_q[lane_sel];
      cma_pkg::BK_ERD2: begin
        sb_q <= ssum_q[lane_sel];
        pe_q <= rd_eff;
      end
      cma_pkg::BK_EMUL: begin
        np_q <= $signed({1'b0, bins_q}) * pe_q;
        ss_q <= sa_q * sb_q;
      end
      cma_pkg::BK_ESUB: begin
        neg_q <= diff[DW-1];
        dq_q  <= diff[DW-1] ? DW'(-diff) : DW'(diff);
        rem_q <= '0;
        cnt_q <= '0;
      end
      // restoring division, one quotient bit a cycle
      cma_pkg::BK_EDIV: begin
        cnt_q <= cnt_q + CW'(1);
        if (trial >= {1'b0, q_q}) begin
          rem_q <= QW'(trial - {1'b0, q_q});
          dq_q  <= {dq_q[DW-2:0], 1'b1};
        end else begin
          rem_q <= trial[QW-1:0];
          dq_q  <= {dq_q[DW-2:0], 1'b0};
        end
      end
      cma_pkg::BK_EMIT: begin
        if (emit_go) begin
          res_q.row  <= ei_q;
          res_q.col  <= ej_q;
          res_q.cov  <= skip_ent ? '0 : cov_v;
          res_q.last <= ent_last;
          if (bins_q < NW'(2)) begin
            res_q.status <= cma_pkg::STATUS_FEW_BINS;
          end else if (ovf_q) begin
            res_q.status <= cma_pkg::STATUS_DROPPED;
          end else begin
            res_q.status <= cma_pkg::STATUS_OK;
          end
          if (col_end) begin
            ej_q <= '0;
            ei_q <= ei_q + XW'(1);
          end else begin
            ej_q <= ej_q + XW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // product-sum store
  always_ff @(posedge clk_i) begin
    if (state_q == cma_pkg::BK_ADD) begin
      psum_mem[p_q] <= rd_eff + PRODW'(prod_q);
    end
    rd_data_q <= psum_mem[raddr];
    rd_hit_q  <= pvalid_q[raddr];
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  a_bins_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bins_q <= BIN_CAP)
    else $error("bin count beyond capacity");

  a_clear_after_matrix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_go && ent_last) |=> (bins_q == '0 && pvalid_q == '0 && !ovf_q))
    else $error("accumulators not cleared after matrix");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cma_pkg::BK_ESUB) |=> (state_q == cma_pkg::BK_EDIV && cnt_q == '0))
    else $error("division did not start cleanly");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != cma_pkg::BK_IDLE && state_q != cma_pkg::BK_EMIT) |=> !res_valid_q
      || $past(res_valid_q))
    else $error("result beat raised outside emit");

endmodule

/* rtl/covariance_matrix_accumulator_core.sv */
// covariance_matrix_accumulator_core: top level with the configuration port
// depends on cma_pkg, cma_front and cma_back
//
// usage: each input beat is one bin, lanes sample_0..sample_7 (signed Q7.16)
// plus last_bin. the block keeps per-lane sums and the upper-triangle product
// sums; a bin with last_bin set closes the set and the N x N matrix comes out
// row-major on the result channel, one beat per entry, last_entry on the end.
// a bin is worked through pair by pair in the back end (P pair products,
// one shared multiplier and a read-modify-write of the product-sum memory).
// each matrix entry goes through the sum and product-sum reads, the multiply,
// the subtract, the bit-serial divider over the DW-bit numerator (DW = 72 at
// the default sizes) and the emit step. a two-entry queue takes bins while
// the back end is busy; a stalled result beat holds the back end in its emit
// step and the queue then fills. reset clears the sums, bin count and
// overflow flag and sets series_in_use to 8 and diagonal_only to 0.
// configuration: series_in_use at byte 0, diagonal_only at byte 4. the user must
// write them only while the block is idle; the block itself does not enforce it.
module covariance_matrix_accumulator_core #(
  parameter int MAX_SERIES   = cma_pkg::DEF_MAX_SERIES,
  parameter int MAX_BINS     = cma_pkg::DEF_MAX_BINS,
  parameter int SAMPLE_WIDTH = cma_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [cma_pkg::IN_W-1:0]    sample_0_i,
  input  logic signed [cma_pkg::IN_W-1:0]    sample_1_i,
  input  logic signed [cma_pkg::IN_W-1:0]    sample_2_i,
  input  logic signed [cma_pkg::IN_W-1:0]    sample_3_i,
  input  logic signed [cma_pkg::IN_W-1:0]    sample_4_i,
  input  logic signed [cma_pkg::IN_W-1:0]    sample_5_i,
  input  logic signed [cma_pkg::IN_W-1:0]    sample_6_i,
  input  logic signed [cma_pkg::IN_W-1:0]    sample_7_i,
  input  logic                               last_bin_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [cma_pkg::IDX_W-1:0]          row_index_o,
  output logic [cma_pkg::IDX_W-1:0]          col_index_o,
  output logic signed [cma_pkg::COV_W-1:0]   covariance_o,
  output logic [1:0]                         status_o,
  output logic                               last_entry_o
);

  logic [cma_pkg::NS_W-1:0]         series_in_use_q;
  logic                             diagonal_only_q;
  logic [cma_pkg::IN_W-1:0]         samples [cma_pkg::NUM_LANES];
  logic [MAX_SERIES*SAMPLE_WIDTH:0] item;
  logic                             item_valid, item_ready;
  cma_pkg::result_t                 res;
  logic                             cfg_wr;

  assign samples[0] = sample_0_i;
  assign samples[1] = sample_1_i;
  assign samples[2] = sample_2_i;
  assign samples[3] = sample_3_i;
  assign samples[4] = sample_4_i;
  assign samples[5] = sample_5_i;
  assign samples[6] = sample_6_i;
  assign samples[7] = sample_7_i;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      series_in_use_q <= cma_pkg::NS_RESET;
      diagonal_only_q <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        cma_pkg::REG_SERIES_IN_USE: series_in_use_q <= pwdata[cma_pkg::NS_W-1:0];
        cma_pkg::REG_DIAGONAL_ONLY: diagonal_only_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      cma_pkg::REG_SERIES_IN_USE: prdata = {{(32-cma_pkg::NS_W){1'b0}}, series_in_use_q};
      cma_pkg::REG_DIAGONAL_ONLY: prdata = {31'd0, diagonal_only_q};
      default:                    prdata = '0;
    endcase
  end

  cma_front #(
    .MAX_SERIES  (MAX_SERIES),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (samples),
    .last_bin_i  (last_bin_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .item_o      (item),
    .item_valid_o(item_valid),
    .item_ready_i(item_ready)
  );

  cma_back #(
    .MAX_SERIES  (MAX_SERIES),
    .MAX_BINS    (MAX_BINS),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item),
    .item_valid_i   (item_valid),
    .item_ready_o   (item_ready),
    .series_in_use_i(series_in_use_q),
    .diagonal_only_i(diagonal_only_q),
    .res_o          (res),
    .res_valid_o    (out_valid_o),
    .res_ready_i    (out_ready_i)
  );

  assign row_index_o  = res.row;
  assign col_index_o  = res.col;
  assign covariance_o = res.cov;
  assign status_o     = res.status;
  assign last_entry_o = res.last;

endmodule

/* tb/sv/cma_checker.sv */
// cma_checker: watches the bin and matrix channels of the covariance accumulator,
// predicts every matrix entry and compares; depends on cma_pkg
module cma_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [31:0]                      cfg_data_i,
  input  logic                             in_fire_i,
  input  logic signed [cma_pkg::IN_W-1:0]  lane_i [8],
  input  logic                             last_bin_i,
  input  logic                             out_fire_i,
  input  logic [cma_pkg::IDX_W-1:0]        row_i,
  input  logic [cma_pkg::IDX_W-1:0]        col_i,
  input  logic signed [cma_pkg::COV_W-1:0] cov_i,
  input  logic [1:0]                       status_i,
  input  logic                             last_i,
  output int                               fail_count_o,
  output int                               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXB = cma_pkg::DEF_MAX_BINS;

  logic signed [63:0]  lane_sum [8];
  logic signed [63:0]  prod_sum [8][8];
  int unsigned         bin_count;
  bit                  dropped;
  logic [3:0]          ns_reg;
  bit                  diag_reg;
  cma_pkg::result_t    entry_q [$];
  int                  fails;

  assign fail_count_o = fails;

  function automatic logic signed [cma_pkg::COV_W-1:0] cov_entry(int a, int b);
    logic signed [127:0] num;
    logic signed [127:0] den;
    logic signed [127:0] quo;
    num = 128'(bin_count) * 128'(prod_sum[a][b]) - 128'(lane_sum[a]) * 128'(lane_sum[b]);
    den = 128'(bin_count) * 128'(bin_count) * 128'(bin_count - 1);
    quo = num / den; // truncates toward zero
    if (quo > 128'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
    if (quo < -128'sh8000_0000_0000) return 48'sh8000_0000_0000;
    return quo[cma_pkg::COV_W-1:0];
  endfunction

  task automatic close_set();
    int               n;
    cma_pkg::result_t r;
    cma_pkg::status_e st;
    n = (ns_reg == 0) ? 1 : (ns_reg > 8 ? 8 : int'(ns_reg));
    st = bin_count < 2 ? cma_pkg::STATUS_FEW_BINS :
         (dropped ? cma_pkg::STATUS_DROPPED : cma_pkg::STATUS_OK);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        r.row = i[cma_pkg::IDX_W-1:0];
        r.col = j[cma_pkg::IDX_W-1:0];
        r.status = st;
        r.last = (i == n - 1) && (j == n - 1);
        r.cov = '0;
        if (bin_count >= 2 && (i == j || !diag_reg))
          r.cov = cov_entry(i < j ? i : j, i < j ? j : i);
        entry_q.push_back(r);
      end
    end
    foreach (lane_sum[k]) lane_sum[k] = 0;
    foreach (prod_sum[a, b]) prod_sum[a][b] = 0;
    bin_count = 0;
    dropped = 0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cma_pkg::result_t want;
    if (!rst_ni) begin
      foreach (lane_sum[k]) lane_sum[k] = 0;
      foreach (prod_sum[a, b]) prod_sum[a][b] = 0;
      bin_count = 0;
      dropped = 0;
      ns_reg = cma_pkg::NS_RESET;
      diag_reg = 0;
      entry_q.delete();
      fails = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == cma_pkg::REG_SERIES_IN_USE) ns_reg = cfg_data_i[3:0];
        else diag_reg = cfg_data_i[0];
      end
      if (out_fire_i) begin
        if (entry_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected entry (%0d,%0d) cov %0d", row_i, col_i, cov_i);
        end else begin
          want = entry_q.pop_front();
          if (want.row !== row_i || want.col !== col_i || want.cov !== cov_i ||
              want.status !== status_i || want.last !== last_i) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: exp (%0d,%0d) %0d st %0d l %0b, got (%0d,%0d) %0d st %0d l %0b",
                       want.row, want.col, want.cov, want.status, want.last,
                       row_i, col_i, cov_i, status_i, last_i);
          end
        end
      end
      if (in_fire_i) begin
        if (bin_count < MAXB) begin
          for (int i = 0; i < 8; i++) begin
            lane_sum[i] += 64'(lane_i[i]);
            for (int j = i; j < 8; j++)
              prod_sum[i][j] += 64'(lane_i[i]) * 64'(lane_i[j]);
          end
          bin_count++;
        end else begin
          dropped = 1;
        end
        if (last_bin_i) close_set();
      end
    end
    pending_o = entry_q.size();
  end
endmodule

/* tb/sv/tb_top.sv */
// tb_top: stimulus and verdict for covariance_matrix_accumulator_core
// depends on cma_pkg, cma_checker and the block's rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 0, in_ready_o;
  logic signed [cma_pkg::IN_W-1:0] lane [8];
  logic last_bin_i = 0;
  logic out_valid_o, out_ready_i = 0;
  logic [cma_pkg::IDX_W-1:0] row_index_o, col_index_o;
  logic signed [cma_pkg::COV_W-1:0] covariance_o;
  logic [1:0] status_o;
  logic last_entry_o;
  int fail_count, pending;
  bit quiet_tail = 0;
  int stall_cycles = 0;

  initial foreach (lane[k]) lane[k] = '0;

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  covariance_matrix_accumulator_core u_top (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o,
    .sample_0_i(lane[0]), .sample_1_i(lane[1]), .sample_2_i(lane[2]),
    .sample_3_i(lane[3]), .sample_4_i(lane[4]), .sample_5_i(lane[5]),
    .sample_6_i(lane[6]), .sample_7_i(lane[7]), .last_bin_i,
    .out_valid_o, .out_ready_i, .row_index_o, .col_index_o, .covariance_o,
    .status_o, .last_entry_o
  );

  cma_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_we_i(psel && penable && pwrite && pready), .cfg_idx_i(paddr[2]),
    .cfg_data_i(pwdata),
    .in_fire_i(in_valid_i && in_ready_o), .lane_i(lane), .last_bin_i,
    .out_fire_i(out_valid_o && out_ready_i), .row_i(row_index_o), .col_i(col_index_o),
    .cov_i(covariance_o), .status_i(status_o), .last_i(last_entry_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // result side back-pressure in bursts
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 15);
        out_ready_i <= 0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1;
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic reg_write(logic reg_idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1; pwrite <= 1; paddr <= {reg_idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // value mixing extremes and random content
  function automatic logic signed [cma_pkg::IN_W-1:0] pick_sample(int mode);
    logic [31:0] rnd;
    rnd = $urandom();
    case (mode)
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return '0;
      3: return 24'(signed'($urandom_range(0, 2000)) - 1000);
      default: return rnd[cma_pkg::IN_W-1:0];
    endcase
  endfunction

  task automatic send_bin(int mode, bit last);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    foreach (lane[k]) lane[k] <= pick_sample(mode < 0 ? $urandom_range(0, 5) : mode);
    last_bin_i <= last;
    in_valid_i <= 1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (pending != 0) @(negedge clk_i);
    // a non-last bin may still be in the back end
    repeat (300) @(negedge clk_i);
  endtask

  initial begin
    int sets;
    repeat (5) @(negedge clk_i);
    rst_ni = 1;
    // directed: single bin, extremes, alternating signs, zero
    send_bin(2, 1);
    send_bin(0, 0); send_bin(0, 1);
    send_bin(0, 0); send_bin(1, 1);
    send_bin(1, 0); send_bin(1, 0); send_bin(3, 1);
    drain();
    reg_write(cma_pkg::REG_DIAGONAL_ONLY, 1);
    reg_write(cma_pkg::REG_SERIES_IN_USE, 3);
    send_bin(5, 0); send_bin(5, 0); send_bin(5, 1);
    drain();
    reg_write(cma_pkg::REG_SERIES_IN_USE, 0);
    send_bin(5, 0); send_bin(5, 1);
    drain();
    reg_write(cma_pkg::REG_SERIES_IN_USE, 15);
    reg_write(cma_pkg::REG_DIAGONAL_ONLY, 0);
    send_bin(5, 0); send_bin(4, 1);
    drain();
    // random sets
    for (sets = 0; sets < 40; sets++) begin
      if (sets == 34) quiet_tail = 1;
      if (sets % 8 == 0) begin
        drain();
        reg_write(cma_pkg::REG_SERIES_IN_USE, $urandom_range(1, 8));
        reg_write(cma_pkg::REG_DIAGONAL_ONLY, $urandom_range(0, 1));
      end
      for (int b = $urandom_range(0, 7); b >= 0; b--) send_bin(-1, b == 0);
    end
    drain();
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

/* filelist.f */
rtl/cma_pkg.sv
rtl/cma_front.sv
rtl/cma_back.sv
rtl/covariance_matrix_accumulator_core.sv
tb/sv/cma_checker.sv
tb/sv/tb_top.sv
